>>> sv/sjf_pkg.sv
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared types and constants of the shortest-job-first batch scheduler.
// ----------------------------------------------------------------------------
package sjf_pkg;

   localparam int MaxJobsDefault = 32;

   localparam int BurstW  = 16;
   localparam int IdW     = 6;
   localparam int WaitW   = 21;
   localparam int TwaitW  = 25;
   localparam int TtatW   = 26;
   localparam int AvgWW   = 28;
   localparam int AvgTW   = 29;

   // controller states
   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_SORT_WR,
      ST_EMIT_RD,
      ST_EMIT_CALC,
      ST_EMIT_OUT,
      ST_DIV,
      ST_FINAL_OUT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic store_job;    // write incoming job at fill position
      logic clear_batch;  // restart batch state
      logic rd_i;         // read entry i into holding register a
      logic rd_j;         // read entry j into holding register b
      logic cmp_swap;     // write both entries swapped when a > b
      logic init_i;       // i <= 0, j <= 1
      logic step_j;       // j++ or i++ and j <= i+1
      logic init_k;       // k <= 0, sums cleared
      logic rd_k;         // read entry k
      logic calc;         // accumulate sums and latch result
      logic step_k;       // k++ and advance prefix
      logic div_start;    // start average division
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic sort_done;    // no pairs left
      logic pair_last;    // current pair is the last one
      logic k_last;       // entry k is the final job
      logic div_done;     // division finished
      logic swap;         // holding a > holding b
   } stat_type;

endpackage

>>> sv/sjf_ctrl.sv
// ----------------------------------------------------------------------------
// sjf_ctrl
// Sequencer for collect, exchange sort, result emission and averaging.
// ----------------------------------------------------------------------------
module sjf_ctrl
   import sjf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_last,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output cmd_type  cmd,
   input  stat_type stat
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_valid && req_last) begin
               state_in = ST_SORT_RD;
            end
         end
         ST_SORT_RD: begin
            state_in = stat.sort_done ? ST_EMIT_RD : ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            state_in = ST_SORT_WR;
         end
         ST_SORT_WR: begin
            state_in = stat.pair_last ? ST_EMIT_RD : ST_SORT_RD;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_CALC;
         end
         ST_EMIT_CALC: begin
            state_in = stat.k_last ? ST_DIV : ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (rsp_ready) begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_FINAL_OUT;
            end
         end
         ST_FINAL_OUT: begin
            if (rsp_ready) begin
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            req_ready     = 1'b1;
            cmd.store_job = req_valid;
            cmd.init_i    = 1'b1;
         end
         ST_SORT_RD: begin
            cmd.rd_i   = 1'b1;
            cmd.rd_j   = 1'b1;
            cmd.init_k = 1'b1;
         end
         ST_SORT_CMP: begin
         end
         ST_SORT_WR: begin
            cmd.cmp_swap = stat.swap;
            cmd.step_j   = 1'b1;
         end
         ST_EMIT_RD: begin
            cmd.rd_k = 1'b1;
         end
         ST_EMIT_CALC: begin
            cmd.calc      = 1'b1;
            cmd.div_start = stat.k_last;
         end
         ST_EMIT_OUT: begin
            rsp_valid   = 1'b1;
            cmd.step_k  = rsp_ready;
         end
         ST_DIV: begin
         end
         ST_FINAL_OUT: begin
            rsp_valid       = 1'b1;
            cmd.clear_batch = rsp_ready;
         end
         default: begin
         end
      endcase
   end

endmodule

>>> sv/sjf_div.sv
// ----------------------------------------------------------------------------
// sjf_div
// Restoring divider, one quotient bit per cycle, for the two averages.
// ----------------------------------------------------------------------------
module sjf_div
   import sjf_pkg::*;
#(
   parameter int NumW = 34,
   parameter int DenW = 7
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NumW-1:0] num,
   input  logic [DenW-1:0] den,
   output logic [NumW-1:0] quo,
   output logic            done
);

   localparam int CntW = $clog2(NumW + 1);

   logic [NumW-1:0] quo_ff, quo_in;
   logic [DenW:0]   rem_ff, rem_in;
   logic [DenW-1:0] den_ff, den_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic [DenW:0]   trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // one shift-subtract step
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[DenW-1:0], quo_ff[NumW-1]};
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CntW'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   assign quo  = quo_ff;
   assign done = !busy_ff && !start;

endmodule

>>> sv/sjf_dpath.sv
// ----------------------------------------------------------------------------
// sjf_dpath
// Job store, sort compare/swap, prefix sums and average dividers.
// ----------------------------------------------------------------------------
module sjf_dpath
   import sjf_pkg::*;
#(
   parameter int MaxJobs = MaxJobsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [BurstW-1:0]   req_burst_time,
   output logic [IdW-1:0]      rsp_job_id,
   output logic [BurstW-1:0]   rsp_job_burst,
   output logic [WaitW-1:0]    rsp_wait_time,
   output logic [WaitW-1:0]    rsp_turnaround_time,
   output logic [TwaitW-1:0]   rsp_total_waiting,
   output logic [TtatW-1:0]    rsp_total_turnaround,
   output logic [AvgWW-1:0]    rsp_avg_waiting_q8,
   output logic [AvgTW-1:0]    rsp_avg_turnaround_q8,
   output logic                rsp_final_res
);

   localparam int AW = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
   localparam int CW = $clog2(MaxJobs + 1);
   localparam int NumWW = TwaitW + 8;
   localparam int NumTW = TtatW + 8;

   // job store: burst and id per entry, two ports
   logic [BurstW+IdW-1:0] mem [MaxJobs];

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [BurstW+IdW-1:0] a_ff, b_ff;
   logic [WaitW-1:0]  prefix_ff, prefix_in;
   logic [TwaitW-1:0] wsum_ff, wsum_in;
   logic [TtatW-1:0]  tsum_ff, tsum_in;
   logic [WaitW-1:0]  tat;
   logic              fin_ff;

   logic [AW-1:0]     wa_addr, wb_addr;
   logic [BurstW+IdW-1:0] wa_data, wb_data;
   logic              wa_en, wb_en;
   logic [NumWW-1:0]  qw;
   logic [NumTW-1:0]  qt;
   logic              dw_done, dt_done;

   // counters
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         i_ff      <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
         prefix_ff <= '0;
         wsum_ff   <= '0;
         tsum_ff   <= '0;
      end else begin
         cnt_ff    <= cnt_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
         prefix_ff <= prefix_in;
         wsum_ff   <= wsum_in;
         tsum_ff   <= tsum_in;
      end
   end

   assign tat = prefix_ff + WaitW'(a_ff[BurstW+IdW-1:IdW]);

   always_comb begin
      cnt_in    = cnt_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      prefix_in = prefix_ff;
      wsum_in   = wsum_ff;
      tsum_in   = tsum_ff;
      if (cmd.store_job && cnt_ff < CW'(MaxJobs)) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.init_i) begin
         i_in = '0;
         j_in = CW'(1);
      end
      if (cmd.step_j) begin
         if (j_ff + 1'b1 >= cnt_ff) begin
            i_in = i_ff + 1'b1;
            j_in = i_ff + CW'(2);
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
      if (cmd.init_k) begin
         k_in      = '0;
         prefix_in = '0;
         wsum_in   = '0;
         tsum_in   = '0;
      end
      if (cmd.calc) begin
         wsum_in = wsum_ff + TwaitW'(prefix_ff);
         tsum_in = tsum_ff + TtatW'(tat);
      end
      if (cmd.step_k) begin
         k_in      = k_ff + 1'b1;
         prefix_in = tat;
      end
      if (cmd.clear_batch) begin
         cnt_in    = '0;
         prefix_in = '0;
         wsum_in   = '0;
         tsum_in   = '0;
      end
   end

   // memory write ports
   always_comb begin
      wa_en   = 1'b0;
      wb_en   = 1'b0;
      wa_addr = i_ff[AW-1:0];
      wb_addr = j_ff[AW-1:0];
      wa_data = b_ff;
      wb_data = a_ff;
      if (cmd.store_job) begin
         wa_en   = cnt_ff < CW'(MaxJobs);
         wa_addr = cnt_ff[AW-1:0];
         wa_data = {req_burst_time, IdW'(cnt_ff + 1'b1)};
      end else if (cmd.cmp_swap) begin
         wa_en = 1'b1;
         wb_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wa_en) begin
         mem[wa_addr] <= wa_data;
      end
      if (wb_en) begin
         mem[wb_addr] <= wb_data;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      if (cmd.rd_i) begin
         a_ff <= mem[i_ff[AW-1:0]];
      end else if (cmd.rd_k) begin
         a_ff <= mem[k_ff[AW-1:0]];
      end
      if (cmd.rd_j) begin
         b_ff <= mem[j_ff[AW-1:0]];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         rsp_job_id           <= a_ff[IdW-1:0];
         rsp_job_burst        <= a_ff[BurstW+IdW-1:IdW];
         rsp_wait_time        <= prefix_ff;
         rsp_turnaround_time  <= tat;
         rsp_total_waiting    <= wsum_ff + TwaitW'(prefix_ff);
         rsp_total_turnaround <= tsum_ff + TtatW'(tat);
         fin_ff               <= stat.k_last;
      end
   end

   sjf_div #(.NumW(NumWW), .DenW(CW)) u_div_w (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   ({wsum_ff + TwaitW'(prefix_ff), 8'h00}),
      .den   (cnt_ff),
      .quo   (qw),
      .done  (dw_done)
   );

   sjf_div #(.NumW(NumTW), .DenW(CW)) u_div_t (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   ({tsum_ff + TtatW'(tat), 8'h00}),
      .den   (cnt_ff),
      .quo   (qt),
      .done  (dt_done)
   );

   assign rsp_final_res         = fin_ff;
   assign rsp_avg_waiting_q8    = fin_ff ? qw[AvgWW-1:0] : '0;
   assign rsp_avg_turnaround_q8 = fin_ff ? qt[AvgTW-1:0] : '0;

   assign stat.sort_done = (cnt_ff < CW'(2)) || (i_ff + 1'b1 >= cnt_ff);
   assign stat.pair_last = (j_ff + 1'b1 >= cnt_ff) && (i_ff + CW'(2) >= cnt_ff);
   assign stat.k_last    = (k_ff + 1'b1 == cnt_ff);
   assign stat.div_done  = dw_done && dt_done;
   assign stat.swap      = a_ff[BurstW+IdW-1:IdW] > b_ff[BurstW+IdW-1:IdW];

endmodule

>>> sv/shortest_job_first_schedule.sv
// Sequence: after the closing item, each sort pair (N*(N-1)/2 pairs) is read,
// compared and swapped if needed; then each result is read, summed and sent.
// Throughput: one item per cycle while collecting; one batch at a time.
// Averages are divided before the final result; outputs wait on rsp_ready.
// Reset: synchronous, active high; clears the controller and batch counters.
// ----------------------------------------------------------------------------
// shortest_job_first_schedule
// Batch shortest-job-first scheduler: collect, exchange sort, emit results.
// ----------------------------------------------------------------------------
module shortest_job_first_schedule
   import sjf_pkg::*;
#(
   parameter int MaxJobs = MaxJobsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BurstW-1:0]  req_burst_time,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [IdW-1:0]     rsp_job_id,
   output logic [BurstW-1:0]  rsp_job_burst,
   output logic [WaitW-1:0]   rsp_wait_time,
   output logic [WaitW-1:0]   rsp_turnaround_time,
   output logic [TwaitW-1:0]  rsp_total_waiting,
   output logic [TtatW-1:0]   rsp_total_turnaround,
   output logic [AvgWW-1:0]   rsp_avg_waiting_q8,
   output logic [AvgTW-1:0]   rsp_avg_turnaround_q8,
   output logic               rsp_final_res
);

   cmd_type  cmd;
   stat_type stat;

   sjf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   sjf_dpath #(.MaxJobs(MaxJobs)) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_burst_time        (req_burst_time),
      .rsp_job_id            (rsp_job_id),
      .rsp_job_burst         (rsp_job_burst),
      .rsp_wait_time         (rsp_wait_time),
      .rsp_turnaround_time   (rsp_turnaround_time),
      .rsp_total_waiting     (rsp_total_waiting),
      .rsp_total_turnaround  (rsp_total_turnaround),
      .rsp_avg_waiting_q8    (rsp_avg_waiting_q8),
      .rsp_avg_turnaround_q8 (rsp_avg_turnaround_q8),
      .rsp_final_res         (rsp_final_res)
   );

endmodule
